@@ rtl/qslerp_pkg.sv @@
// shared types, widths and constants of the quaternion slerp pipeline
package qslerp_pkg;

  localparam int unsigned NumComp    = 4;
  localparam int unsigned NumLevels  = 16;   // one level per fraction bit
  localparam int unsigned CompW      = 16;   // q1.15 component
  localparam int unsigned QnW        = 17;   // component after negation, holds +1.0
  localparam int unsigned FracW      = 17;   // q1.16 fraction, 65536 is 1.0
  localparam int unsigned TbW        = 16;   // fraction bits walked by the levels
  localparam int unsigned ProdW      = 32;   // component product, q2.30
  localparam int unsigned DotW       = 34;   // sum of four products
  localparam int unsigned GW         = 32;   // 1 + cosine term, q.30
  localparam int unsigned DivShift   = 29;
  localparam int unsigned RootArgW   = GW + DivShift;      // square root radicand
  localparam int unsigned SqrtSteps  = (RootArgW + 1) / 2;
  localparam int unsigned HW         = 31;   // half-angle cosine, up to 1.0 in q.30
  localparam int unsigned WeightW    = 33;   // weight, up to 4.0 in q.30
  localparam int unsigned QuoW       = WeightW + 1;
  localparam int unsigned DivSteps   = QuoW;
  localparam int unsigned RemW       = QuoW + DivShift + 1;
  localparam int unsigned MulW       = WeightW + 1 + QnW;  // weight times component
  localparam int unsigned AccW       = MulW + 1;
  localparam int unsigned OutShift   = 30;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned ThrW       = 8;
  localparam int unsigned OutDepthDef = 2;

  localparam logic [CfgIdxW-1:0] CfgAdjustSign      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLinearThreshold = 2'd1;

  localparam logic [FracW-1:0]   FracOne    = 17'h10000;
  localparam logic [WeightW-1:0] WeightOne  = 33'h0_4000_0000;
  localparam logic [WeightW-1:0] WeightMax  = 33'h1_0000_0000;
  localparam logic [GW-1:0]      GOne       = 32'h4000_0000;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [QnW-1:0]   qn_t;
  typedef logic [WeightW-1:0]      weight_t;

  typedef struct packed {
    logic            adjust_sign;
    logic [ThrW-1:0] linear_threshold;
  } cfg_t;

  typedef struct packed {
    comp_t [NumComp-1:0] p;
    qn_t   [NumComp-1:0] q;
    logic  [FracW-1:0]   frac;
    logic  [TbW-1:0]     tb;
    logic                slerp;
    logic  [GW-1:0]      g;
    weight_t             ap;
    weight_t             aq;
    weight_t             bp;
    weight_t             bq;
  } item_t;

  typedef struct packed {
    item_t               item;
    logic [RootArgW-1:0] v;
    logic [RootArgW-1:0] r;
  } sqrt_t;

  typedef struct packed {
    item_t           item;
    logic [HW-1:0]   h;
    logic [RemW-1:0] remp;
    logic [RemW-1:0] remq;
    logic [QuoW-1:0] quop;
    logic [QuoW-1:0] quoq;
  } div_t;

endpackage

@@ rtl/qslerp_front.sv @@
// front stages: component products, dot product, sign flip, clamp and path choice
module qslerp_front (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           en_i,
  input  logic                                           vld_i,
  input  qslerp_pkg::comp_t [qslerp_pkg::NumComp-1:0]    p_i,
  input  qslerp_pkg::comp_t [qslerp_pkg::NumComp-1:0]    q_i,
  input  logic [qslerp_pkg::FracW-1:0]                   frac_i,
  input  qslerp_pkg::cfg_t                               cfg_i,
  output logic                                           vld_o,
  output qslerp_pkg::item_t                              item_o
);

  localparam int unsigned N     = qslerp_pkg::NumComp;
  localparam int unsigned DotW  = qslerp_pkg::DotW;
  localparam int unsigned ProdW = qslerp_pkg::ProdW;
  localparam int unsigned GW    = qslerp_pkg::GW;
  localparam logic signed [DotW-1:0] DotOne = DotW'(1) << 30;

  logic                                 vld1_q;
  logic signed [ProdW-1:0]              prod_q [N];
  qslerp_pkg::comp_t [N-1:0]            p1_q;
  qslerp_pkg::comp_t [N-1:0]            q1_q;
  logic [qslerp_pkg::FracW-1:0]         frac1_q;

  logic                                 vld2_q;
  qslerp_pkg::item_t                    item_d;
  qslerp_pkg::item_t                    item_q;

  logic signed [DotW-1:0] dot;
  logic signed [DotW-1:0] dot_adj;
  logic signed [DotW-1:0] dot_clamp;
  logic signed [DotW-1:0] omc;
  logic signed [DotW-1:0] gsum;
  logic                   neg;

  // stage one: four products, fraction clipped to 1.0
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        prod_q[i] <= $signed(p_i[i]) * $signed(q_i[i]);
      end
      p1_q    <= p_i;
      q1_q    <= q_i;
      frac1_q <= (frac_i > qslerp_pkg::FracOne) ? qslerp_pkg::FracOne : frac_i;
    end
  end

  // stage two: cosine, shortest path flip, clamp, linear or slerp
  always_comb begin
    dot = DotW'(prod_q[0]) + DotW'(prod_q[1]) + DotW'(prod_q[2]) + DotW'(prod_q[3]);
    neg = cfg_i.adjust_sign && dot[DotW-1];
    dot_adj = neg ? -dot : dot;
    if (dot_adj > DotOne) begin
      dot_clamp = DotOne;
    end else if (dot_adj < -DotOne) begin
      dot_clamp = -DotOne;
    end else begin
      dot_clamp = dot_adj;
    end
    omc  = DotOne - dot_clamp;
    gsum = dot_clamp + DotOne;

    item_d.p     = p1_q;
    for (int i = 0; i < N; i++) begin
      item_d.q[i] = neg ? -qslerp_pkg::QnW'($signed(q1_q[i]))
                        : qslerp_pkg::QnW'($signed(q1_q[i]));
    end
    item_d.frac  = frac1_q;
    item_d.tb    = frac1_q[qslerp_pkg::TbW-1:0];
    item_d.slerp = omc[GW-1:0] > GW'({cfg_i.linear_threshold, 15'b0});
    item_d.g     = gsum[GW-1:0];
    item_d.ap    = qslerp_pkg::WeightOne;
    item_d.aq    = '0;
    item_d.bp    = '0;
    item_d.bq    = qslerp_pkg::WeightOne;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  assign vld_o  = vld2_q;
  assign item_o = item_q;

endmodule

@@ rtl/qslerp_level.sv @@
// one bisection level: pipelined half-angle square root, two pipelined divides, pick
module qslerp_level (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  qslerp_pkg::item_t item_i,
  output logic              vld_o,
  output qslerp_pkg::item_t item_o
);

  localparam int unsigned Sq       = qslerp_pkg::SqrtSteps;
  localparam int unsigned Dv       = qslerp_pkg::DivSteps;
  localparam int unsigned RootArgW = qslerp_pkg::RootArgW;
  localparam int unsigned RemW     = qslerp_pkg::RemW;
  localparam int unsigned QuoW     = qslerp_pkg::QuoW;
  localparam int unsigned HW       = qslerp_pkg::HW;
  localparam int unsigned WeightW  = qslerp_pkg::WeightW;

  qslerp_pkg::sqrt_t sq_in [Sq];
  qslerp_pkg::sqrt_t sq_q  [Sq];
  logic [Sq-1:0]     sq_vld_q;

  qslerp_pkg::div_t  dv_in [Dv];
  qslerp_pkg::div_t  dv_q  [Dv];
  logic [Dv-1:0]     dv_vld_q;

  qslerp_pkg::item_t sel_d;
  qslerp_pkg::item_t sel_q;
  logic              sel_vld_q;

  logic [QuoW-1:0]   sp0;
  logic [QuoW-1:0]   sq0;
  qslerp_pkg::weight_t mp;
  qslerp_pkg::weight_t mq;

  function automatic qslerp_pkg::weight_t mid_sat(qslerp_pkg::weight_t a,
                                                  qslerp_pkg::weight_t b,
                                                  logic [HW-1:0] h,
                                                  logic [QuoW-1:0] quo);
    logic [QuoW-1:0] s;
    logic [QuoW-1:0] m;
    s = QuoW'(a) + QuoW'(b);
    m = (h == '0) ? s : quo;   // antipodal pair, no divide
    return (m > QuoW'(qslerp_pkg::WeightMax)) ? qslerp_pkg::WeightMax : m[WeightW-1:0];
  endfunction

  // square root, one result bit per stage
  assign sq_in[0] = '{item: item_i, v: {item_i.g, {qslerp_pkg::DivShift{1'b0}}}, r: '0};

  for (genvar j = 0; j < Sq; j++) begin : g_sqrt
    localparam logic [RootArgW-1:0] SqBit = RootArgW'(1) << (RootArgW - 1 - 2 * j);
    qslerp_pkg::sqrt_t nxt;
    logic [RootArgW:0] trial;

    if (j > 0) begin : g_link
      assign sq_in[j] = sq_q[j-1];
    end

    always_comb begin
      nxt   = sq_in[j];
      trial = {1'b0, sq_in[j].r} + {1'b0, SqBit};
      if ({1'b0, sq_in[j].v} >= trial) begin
        nxt.v = sq_in[j].v - trial[RootArgW-1:0];
        nxt.r = (sq_in[j].r >> 1) + SqBit;
      end else begin
        nxt.r = sq_in[j].r >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[j] <= nxt;
      end
    end
  end

  // divides share the new half-angle cosine, one quotient bit per stage
  always_comb begin
    sp0 = QuoW'(sq_q[Sq-1].item.ap) + QuoW'(sq_q[Sq-1].item.bp);
    sq0 = QuoW'(sq_q[Sq-1].item.aq) + QuoW'(sq_q[Sq-1].item.bq);
    dv_in[0].item = sq_q[Sq-1].item;
    dv_in[0].h    = sq_q[Sq-1].r[HW-1:0];
    dv_in[0].remp = {1'b0, sp0, {qslerp_pkg::DivShift{1'b0}}};
    dv_in[0].remq = {1'b0, sq0, {qslerp_pkg::DivShift{1'b0}}};
    dv_in[0].quop = '0;
    dv_in[0].quoq = '0;
  end

  for (genvar j = 0; j < Dv; j++) begin : g_div
    localparam int unsigned K = Dv - 1 - j;
    qslerp_pkg::div_t nxt;
    logic [RemW-1:0]  hk;

    if (j > 0) begin : g_link
      assign dv_in[j] = dv_q[j-1];
    end

    always_comb begin
      nxt = dv_in[j];
      hk  = RemW'(dv_in[j].h) << K;
      if (dv_in[j].remp >= hk) begin
        nxt.remp    = dv_in[j].remp - hk;
        nxt.quop[K] = 1'b1;
      end
      if (dv_in[j].remq >= hk) begin
        nxt.remq    = dv_in[j].remq - hk;
        nxt.quoq[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j] <= nxt;
      end
    end
  end

  // midpoint replaces the end that the fraction bit points away from
  always_comb begin
    sel_d = dv_q[Dv-1].item;
    mp = mid_sat(dv_q[Dv-1].item.ap, dv_q[Dv-1].item.bp, dv_q[Dv-1].h, dv_q[Dv-1].quop);
    mq = mid_sat(dv_q[Dv-1].item.aq, dv_q[Dv-1].item.bq, dv_q[Dv-1].h, dv_q[Dv-1].quoq);
    if (dv_q[Dv-1].item.tb[qslerp_pkg::TbW-1]) begin
      sel_d.ap = mp;
      sel_d.aq = mq;
    end else begin
      sel_d.bp = mp;
      sel_d.bq = mq;
    end
    sel_d.tb = dv_q[Dv-1].item.tb << 1;
    sel_d.g  = qslerp_pkg::GW'(dv_q[Dv-1].h) + qslerp_pkg::GOne;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= '0;
      dv_vld_q  <= '0;
      sel_vld_q <= 1'b0;
    end else if (en_i) begin
      sq_vld_q  <= {sq_vld_q[Sq-2:0], vld_i};
      dv_vld_q  <= {dv_vld_q[Dv-2:0], sq_vld_q[Sq-1]};
      sel_vld_q <= dv_vld_q[Dv-1];
    end
  end

  assign vld_o  = sel_vld_q;
  assign item_o = sel_q;

endmodule

@@ rtl/qslerp_back.sv @@
// back stages: weight choice, weighted sum, rounding and saturation to q1.15
module qslerp_back (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        vld_i,
  input  qslerp_pkg::item_t                           item_i,
  output logic                                        vld_o,
  output qslerp_pkg::comp_t [qslerp_pkg::NumComp-1:0] res_o
);

  localparam int unsigned N     = qslerp_pkg::NumComp;
  localparam int unsigned MulW  = qslerp_pkg::MulW;
  localparam int unsigned AccW  = qslerp_pkg::AccW;
  localparam int unsigned WeightW = qslerp_pkg::WeightW;
  localparam logic signed [AccW-1:0] RoundBias = AccW'(1) << (qslerp_pkg::OutShift - 1);
  localparam logic signed [AccW-1:0] SatHi = AccW'(32767);
  localparam logic signed [AccW-1:0] SatLo = -AccW'(32768);

  qslerp_pkg::weight_t wp;
  qslerp_pkg::weight_t wq;
  logic [qslerp_pkg::FracW-1:0] rest;

  logic signed [MulW-1:0] mp_q [N];
  logic signed [MulW-1:0] mq_q [N];
  logic                   vld1_q;

  logic signed [AccW-1:0] acc  [N];
  logic signed [AccW-1:0] shr  [N];
  qslerp_pkg::comp_t [N-1:0] res_d;
  qslerp_pkg::comp_t [N-1:0] res_q;
  logic                   vld2_q;

  always_comb begin
    rest = qslerp_pkg::FracOne - item_i.frac;
    if (!item_i.slerp) begin
      wp = WeightW'({rest, 14'b0});
      wq = WeightW'({item_i.frac, 14'b0});
    end else if (item_i.frac == qslerp_pkg::FracOne) begin
      wp = '0;
      wq = qslerp_pkg::WeightOne;
    end else begin
      wp = item_i.ap;
      wq = item_i.aq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        mp_q[i] <= $signed({1'b0, wp}) * $signed(item_i.p[i]);
        mq_q[i] <= $signed({1'b0, wq}) * $signed(item_i.q[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      acc[i] = AccW'(mp_q[i]) + AccW'(mq_q[i]) + RoundBias;
      shr[i] = acc[i] >>> qslerp_pkg::OutShift;
      if (shr[i] > SatHi) begin
        res_d[i] = 16'sh7fff;
      end else if (shr[i] < SatLo) begin
        res_d[i] = 16'sh8000;
      end else begin
        res_d[i] = shr[i][qslerp_pkg::CompW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  assign vld_o = vld2_q;
  assign res_o = res_q;

endmodule

@@ rtl/quaternion_slerp.sv @@
// top level of the quaternion slerp block: config registers, pipeline and output queue
//
//   channel  direction  handshake                 beat contents
//   in       sink       in_valid_i / in_ready_o   start_q0..3, end_q0..3, fraction
//   out      source     out_valid_o / out_ready_i out_q0..3
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one input beat can be taken every cycle while the queue has room; a result beat
// is offered once its input beat has passed 16 bisection levels of 66
// stages each (31 square root stages, 34 divide stages, one pick stage)
// plus two front and two back stages, and has been written into the queue
// reset clears all valid bits and the queue, config returns to adjust on, threshold 3
// the whole pipeline holds while the output queue is full; in_ready_o follows it
module quaternion_slerp #(
  parameter int unsigned OutDepth = qslerp_pkg::OutDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [15:0]                 start_q0_i,
  input  logic signed [15:0]                 start_q1_i,
  input  logic signed [15:0]                 start_q2_i,
  input  logic signed [15:0]                 start_q3_i,
  input  logic signed [15:0]                 end_q0_i,
  input  logic signed [15:0]                 end_q1_i,
  input  logic signed [15:0]                 end_q2_i,
  input  logic signed [15:0]                 end_q3_i,
  input  logic [16:0]                        fraction_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [15:0]                 out_q0_o,
  output logic signed [15:0]                 out_q1_o,
  output logic signed [15:0]                 out_q2_o,
  output logic signed [15:0]                 out_q3_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [qslerp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [qslerp_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned N     = qslerp_pkg::NumComp;
  localparam int unsigned NL    = qslerp_pkg::NumLevels;
  localparam int unsigned PtrW  = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW  = $clog2(OutDepth + 1);

  // config registers
  qslerp_pkg::cfg_t cfg_q;

  // pipeline enable: everything moves while the queue has room
  logic en;

  qslerp_pkg::comp_t [N-1:0] p_in;
  qslerp_pkg::comp_t [N-1:0] q_in;

  qslerp_pkg::item_t lv_item [NL+1];
  logic [NL:0]       lv_vld;

  logic                      bk_vld;
  qslerp_pkg::comp_t [N-1:0] bk_res;

  // output queue
  qslerp_pkg::comp_t [N-1:0] fifo_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  // config writes, indexes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adjust_sign      <= 1'b1;
      cfg_q.linear_threshold <= 8'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qslerp_pkg::CfgAdjustSign:      cfg_q.adjust_sign      <= cfg_data_i[0];
        qslerp_pkg::CfgLinearThreshold: cfg_q.linear_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = cnt_q < CntW'(OutDepth);
  assign in_ready_o = en;

  assign p_in = {start_q3_i, start_q2_i, start_q1_i, start_q0_i};
  assign q_in = {end_q3_i, end_q2_i, end_q1_i, end_q0_i};

  // products, cosine, path choice
  qslerp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i & in_ready_o),
    .p_i    (p_in),
    .q_i    (q_in),
    .frac_i (fraction_i),
    .cfg_i  (cfg_q),
    .vld_o  (lv_vld[0]),
    .item_o (lv_item[0])
  );

  // one level per fraction bit, most significant first
  for (genvar l = 0; l < NL; l++) begin : g_level
    qslerp_level u_level (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (lv_vld[l]),
      .item_i (lv_item[l]),
      .vld_o  (lv_vld[l+1]),
      .item_o (lv_item[l+1])
    );
  end

  // weighted sum and rounding
  qslerp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (lv_vld[NL]),
    .item_i (lv_item[NL]),
    .vld_o  (bk_vld),
    .res_o  (bk_res)
  );

  // output queue decouples a stalled consumer from the pipeline
  assign push = bk_vld & en;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= bk_res;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign out_q0_o    = fifo_q[rd_ptr_q][0];
  assign out_q1_o    = fifo_q[rd_ptr_q][1];
  assign out_q2_o    = fifo_q[rd_ptr_q][2];
  assign out_q3_o    = fifo_q[rd_ptr_q][3];

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(OutDepth))
    else $error("output queue count above depth");

  // a result beat leaving with nothing arriving lowers the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("output queue count lost a pop");

  // a finished item arriving with nothing leaving raises the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("output queue count lost a push");

endmodule

@@ dv/tb_quaternion_slerp.sv @@
// self-checking testbench for the quaternion slerp block with a bit-exact predictor
module tb_quaternion_slerp;
  timeunit 1ns;
  timeprecision 1ps;

  // register indexes outside the list, writes there must be ignored
  localparam logic [qslerp_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [qslerp_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam longint          OneQ30     = 64'sd1 << 30;
  localparam longint unsigned WLimit     = 64'd1 << 32;
  localparam int              MaxCycles  = 400000;  // many times the slowest legal run
  localparam int              HoldCycles = 2500;    // long receiver hold-off
  localparam int              DrainWait  = 1200;    // beyond the pipeline latency

  // receiver stall patterns
  localparam int RxAlways  = 0;
  localparam int RxHalf    = 1;
  localparam int RxQuarter = 2;

  typedef struct packed {
    qslerp_pkg::comp_t [3:0]      s;
    qslerp_pkg::comp_t [3:0]      e;
    logic [qslerp_pkg::FracW-1:0] frac;
  } slerp_beat_t;

  typedef qslerp_pkg::comp_t [3:0] quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  qslerp_pkg::comp_t [3:0]         start_q = '0;
  qslerp_pkg::comp_t [3:0]         end_q = '0;
  logic [qslerp_pkg::FracW-1:0]    fraction_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  qslerp_pkg::comp_t               out_q0_o, out_q1_o, out_q2_o, out_q3_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [qslerp_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [qslerp_pkg::CfgDataW-1:0] cfg_data_i = '0;

  quaternion_slerp dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_q0_i  (start_q[0]),
    .start_q1_i  (start_q[1]),
    .start_q2_i  (start_q[2]),
    .start_q3_i  (start_q[3]),
    .end_q0_i    (end_q[0]),
    .end_q1_i    (end_q[1]),
    .end_q2_i    (end_q[2]),
    .end_q3_i    (end_q[3]),
    .fraction_i  (fraction_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_q0_o    (out_q0_o),
    .out_q1_o    (out_q1_o),
    .out_q2_o    (out_q2_o),
    .out_q3_o    (out_q3_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: own copy of the two registers, tracked from accepted cfg beats
  // ---------------------------------------------------------------------------
  logic                        adj_model = 1'b1;
  logic [qslerp_pkg::ThrW-1:0] thr_model = 8'd3;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  // bisection midpoint on the arc, capped at 4.0
  function automatic longint unsigned arc_mid(longint unsigned a, longint unsigned b,
                                              longint unsigned h);
    longint unsigned s, m;
    s = a + b;
    m = (h == 0) ? s : ((s << 29) / h);
    return (m > WLimit) ? WLimit : m;
  endfunction

  function automatic quat_t slerp_predict(slerp_beat_t b, logic adj,
                                          logic [qslerp_pkg::ThrW-1:0] thr);
    longint          p[4], q[4];
    longint          dot, acc, y;
    longint unsigned t, wp, wq, ap, aq, bp, bq, onep, mp, mq;
    longint unsigned h[17];
    quat_t           res;
    dot = 0;
    for (int i = 0; i < 4; i++) begin
      p[i] = longint'(b.s[i]);
      q[i] = longint'(b.e[i]);
      dot += p[i] * q[i];
    end
    t = (b.frac > qslerp_pkg::FracOne) ? 64'd65536 : longint'(b.frac);
    // shortest path: flip the end quaternion, -(-1.0) stays exactly +1.0
    if (adj && dot < 0) begin
      dot = -dot;
      for (int i = 0; i < 4; i++) q[i] = -q[i];
    end
    if (dot > OneQ30) dot = OneQ30;
    if (dot < -OneQ30) dot = -OneQ30;

    if (longint'(OneQ30 - dot) > (longint'(thr) <<< 15)) begin
      if (t == 65536) begin
        wp = 0;
        wq = OneQ30;
      end else begin
        ap = OneQ30; aq = 0;
        bp = 0;      bq = OneQ30;
        h[0] = dot + OneQ30;
        for (int d = 0; d < 16; d++) begin
          onep = (d == 0) ? h[0] : (OneQ30 + h[d]);
          h[d+1] = root_floor(onep << 29);
        end
        for (int d = 0; d < 16; d++) begin
          mp = arc_mid(ap, bp, h[d+1]);
          mq = arc_mid(aq, bq, h[d+1]);
          if ((t >> (15 - d)) & 1) begin
            ap = mp; aq = mq;
          end else begin
            bp = mp; bq = mq;
          end
        end
        wp = ap;
        wq = aq;
      end
    end else begin
      wp = (65536 - t) << 14;
      wq = t << 14;
    end

    for (int i = 0; i < 4; i++) begin
      acc = longint'(wp) * p[i] + longint'(wq) * q[i];
      y = (acc + (64'sd1 <<< 29)) >>> 30;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      res[i] = qslerp_pkg::comp_t'(y);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: samples every handshake at the rising edge
  // ---------------------------------------------------------------------------
  quat_t expected_out_q[$];
  int    errors = 0;
  int    results_seen = 0;
  int    slerp_beats = 0;
  int    in_stall_cycles = 0;
  int    cycle = 0;
  logic  in_taken = 1'b0;
  logic  cfg_seen = 1'b0;

  always @(posedge clk_i) begin
    quat_t got, want;
    slerp_beat_t beat;
    int bad;
    bad = 0;
    cycle <= cycle + 1;
    if (cycle > MaxCycles) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_out_q.size());
      $display("tb_quaternion_slerp NOT OK");
      $finish;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      cfg_seen <= cfg_valid_i && cfg_ready_o;
      if (in_valid_i && !in_ready_o && rst_ni) in_stall_cycles <= in_stall_cycles + 1;

      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == qslerp_pkg::CfgAdjustSign) begin
          adj_model = cfg_data_i[0];
        end else if (cfg_index_i == qslerp_pkg::CfgLinearThreshold) begin
          thr_model = cfg_data_i[qslerp_pkg::ThrW-1:0];
        end
      end

      if (in_valid_i && in_ready_o) begin
        beat = '{s: start_q, e: end_q, frac: fraction_i};
        expected_out_q = {expected_out_q, slerp_predict(beat, adj_model, thr_model)};
        slerp_beats <= slerp_beats + 1;
      end

      if (out_valid_o && out_ready_i) begin
        got = '{out_q3_o, out_q2_o, out_q1_o, out_q0_o};
        results_seen <= results_seen + 1;
        if (expected_out_q.size() == 0) begin
          bad = 1;
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
        end else begin
          want = expected_out_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              bad = bad + 1;
              $display("%0t: out_q%0d mismatch, expected %0d actual %0d",
                       $time, i, want[i], got[i]);
            end
          end
        end
        errors <= errors + bad;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of beats from the pending queue, random gaps in between
  // ---------------------------------------------------------------------------
  slerp_beat_t pending_q[$];
  int   burst_left = 4;
  int   gap_left = 0;
  logic sparse_gaps = 1'b0;   // single beats with long gaps, used while the receiver holds off

  always @(negedge clk_i) begin
    slerp_beat_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        start_q <= nxt.s;
        end_q <= nxt.e;
        fraction_i <= nxt.frac;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          if (sparse_gaps) begin
            burst_left <= 1;
            gap_left <= $urandom_range(20, 60);
          end else begin
            burst_left <= $urandom_range(1, 30);
            if ($urandom_range(0, 3) == 0) gap_left <= 0;
            else gap_left <= $urandom_range(1, 6);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: changing stall pattern plus one long hold-off on request
  // ---------------------------------------------------------------------------
  int   rx_mode = RxAlways;
  int   rx_mode_left = 200;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_started = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(RxAlways, RxQuarter);
        rx_mode_left <= $urandom_range(20, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RxAlways: begin
          out_ready_i <= 1'b1;
        end
        RxHalf: begin
          out_ready_i <= $urandom_range(0, 1);
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic slerp_beat_t mk(int s0, int s1, int s2, int s3,
                                     int e0, int e1, int e2, int e3, int f);
    slerp_beat_t b;
    b.s = '{qslerp_pkg::comp_t'(s3), qslerp_pkg::comp_t'(s2),
            qslerp_pkg::comp_t'(s1), qslerp_pkg::comp_t'(s0)};
    b.e = '{qslerp_pkg::comp_t'(e3), qslerp_pkg::comp_t'(e2),
            qslerp_pkg::comp_t'(e1), qslerp_pkg::comp_t'(e0)};
    b.frac = qslerp_pkg::FracW'(f);
    return b;
  endfunction

  function automatic quat_t rand_unit();
    real   r[4];
    real   n;
    quat_t u;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      r[i] = real'(int'($urandom_range(0, 65535)) - 32768);
      n += r[i] * r[i];
    end
    if (n < 1.0) n = 1.0;
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) u[i] = qslerp_pkg::comp_t'(int'(r[i] / n * 32767.0));
    return u;
  endfunction

  function automatic qslerp_pkg::comp_t clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return qslerp_pkg::comp_t'(v);
  endfunction

  // mostly unit pairs and near-equal or near-opposite pairs, the rest raw noise
  function automatic slerp_beat_t rand_beat();
    slerp_beat_t b;
    int          sel, flip;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      b.s = rand_unit();
      b.e = rand_unit();
    end else if (sel < 75) begin
      b.s = rand_unit();
      flip = $urandom_range(0, 1) ? -1 : 1;
      for (int i = 0; i < 4; i++)
        b.e[i] = clip16(flip * (int'(b.s[i]) + int'($urandom_range(0, 64)) - 32));
    end else begin
      for (int i = 0; i < 4; i++) begin
        b.s[i] = qslerp_pkg::comp_t'($urandom);
        b.e[i] = qslerp_pkg::comp_t'($urandom);
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 80) b.frac = qslerp_pkg::FracW'($urandom_range(0, 65536));
    else if (sel < 90) b.frac = $urandom_range(0, 1) ? qslerp_pkg::FracOne : '0;
    else b.frac = qslerp_pkg::FracW'($urandom_range(0, 131071));
    return b;
  endfunction

  task automatic cfg_write(logic [qslerp_pkg::CfgIdxW-1:0] idx,
                           logic [qslerp_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(negedge clk_i); while (!cfg_seen);
    cfg_valid_i = 1'b0;
  endtask

  task automatic add_pending(slerp_beat_t b);
    pending_q = {pending_q, b};
  endtask

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++) add_pending(rand_beat());
  endtask

  // block is idle once every beat went in and every result came back
  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_out_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset settings: adjust on, threshold 3
    // equal inputs take the linear path
    add_pending(mk(32767, 0, 0, 0, 32767, 0, 0, 0, 0));
    add_pending(mk(32767, 0, 0, 0, 32767, 0, 0, 0, 32768));
    add_pending(mk(32767, 0, 0, 0, 32767, 0, 0, 0, 65536));
    // right angle, slerp path across the fraction range, fraction above one
    add_pending(mk(32767, 0, 0, 0, 0, 32767, 0, 0, 0));
    add_pending(mk(32767, 0, 0, 0, 0, 32767, 0, 0, 1));
    add_pending(mk(32767, 0, 0, 0, 0, 32767, 0, 0, 16384));
    add_pending(mk(32767, 0, 0, 0, 0, 32767, 0, 0, 32768));
    add_pending(mk(32767, 0, 0, 0, 0, 32767, 0, 0, 65535));
    add_pending(mk(32767, 0, 0, 0, 0, 32767, 0, 0, 65536));
    add_pending(mk(32767, 0, 0, 0, 0, 32767, 0, 0, 65537));
    add_pending(mk(32767, 0, 0, 0, 0, 32767, 0, 0, 131071));
    // negative dot, flipped end holds the negated minimum component
    add_pending(mk(32767, 0, 0, 0, -32768, 0, 0, 0, 20000));
    add_pending(mk(23170, 23170, 0, 0, -32768, 0, 0, 0, 40000));
    // non-unit inputs, the cosine clamps
    add_pending(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 30000));
    add_pending(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                   12345));
    add_pending(mk(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 50000));
    // one minus cosine below the threshold, the second pair just under it
    add_pending(mk(32767, 0, 0, 0, 32767, 0, 0, 0, 7));
    add_pending(mk(32767, 0, 0, 0, 32766, 0, 0, 0, 9999));
    drain();

    // adjust off, threshold 0: antipodal pair and large weights
    cfg_write(qslerp_pkg::CfgAdjustSign, 8'h00);
    cfg_write(qslerp_pkg::CfgLinearThreshold, 8'h00);
    add_pending(mk(16384, 16384, 16384, 16384, -16384, -16384, -16384, -16384, 21845));
    add_pending(mk(16384, 16384, 16384, 16384, -16384, -16384, -16384, -16384, 1));
    add_pending(mk(32767, 0, 0, 0, -32767, 0, 0, 0, 32768));
    add_pending(mk(32767, 0, 0, 0, -32000, 7000, 0, 0, 3000));
    add_pending(mk(0, 0, 0, 0, 0, 0, 0, 0, 65535));
    queue_random(80);
    drain();

    // adjust on (upper data bits must be masked), widest threshold
    cfg_write(qslerp_pkg::CfgAdjustSign, 8'hff);
    cfg_write(qslerp_pkg::CfgLinearThreshold, 8'hff);
    queue_random(80);
    drain();

    // spare indexes are ignored, adjust off via a masked write, threshold 1
    cfg_write(CfgSpareA, 8'h5a);
    cfg_write(CfgSpareB, 8'ha5);
    cfg_write(qslerp_pkg::CfgAdjustSign, 8'hfe);
    cfg_write(qslerp_pkg::CfgLinearThreshold, 8'h01);
    queue_random(80);
    drain();

    // adjust on, mid threshold; sparse sender while the receiver holds off
    cfg_write(qslerp_pkg::CfgAdjustSign, 8'h01);
    cfg_write(qslerp_pkg::CfgLinearThreshold, 8'h80);
    sparse_gaps = 1'b1;
    hold_req = 1'b1;
    queue_random(60);
    drain();
    sparse_gaps = 1'b0;
    queue_random(100);
    drain();

    repeat (DrainWait) @(negedge clk_i);
    $display("run covered %0d input beats and %0d result beats over five register settings",
             slerp_beats, results_seen);
    $display("input held back by the block for %0d cycles, %0d mismatches",
             in_stall_cycles, errors);
    if (errors == 0 && expected_out_q.size() == 0) begin
      $display("tb_quaternion_slerp OK");
    end else begin
      $display("tb_quaternion_slerp NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/qslerp_pkg.sv
rtl/qslerp_front.sv
rtl/qslerp_level.sv
rtl/qslerp_back.sv
rtl/quaternion_slerp.sv
dv/tb_quaternion_slerp.sv
